[design/keyed_record_table_top_macros.svh]
// Assertion helpers for the record table; both are clocked on i_clk and
// are off while i_rst_n is low.
`ifndef KEYED_RECORD_TABLE_TOP_MACROS_SVH
`define KEYED_RECORD_TABLE_TOP_MACROS_SVH

// cons must hold in the same cycle as ante
`define KRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("krt assertion failed");

// cons must hold in the cycle after ante
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("krt assertion failed");

`endif

[design/krt_pkg.sv]
`timescale 1ns / 1ps

package krt_pkg;

    localparam int DEPTH  = 128;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // request kinds
    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_LOOKUP = 3'd1;
    localparam logic [2:0] REQ_SETQTY = 3'd2;
    localparam logic [2:0] REQ_DELETE = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // result status
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOKEY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_POS   = 2'd3;

    // result data select
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_ALL  = 2'd1;
    localparam logic [1:0] SEL_QTY  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] item_key;
        logic signed [31:0] new_quantity;
        logic [31:0]        new_price;
        logic [6:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] found_key;
        logic signed [31:0] found_quantity;
        logic [31:0]        found_price;
        logic [7:0]         record_count;
    } t_res;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] qty;
        logic [31:0] price;
    } t_record;

    // controller -> datapath
    typedef struct packed {
        logic       load;       // latch request, clear scan pointer
        logic       issue;      // memory read this cycle
        logic       rd_pos;     // read address is the request position
        logic       shift_init; // pointer to entry after the hit
        logic       wr_append;
        logic       wr_set;
        logic       wr_shift;
        logic       finish;     // register the result
        logic       dec;        // one record removed
        logic [1:0] fin_status;
        logic [1:0] fin_sel;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] req_type;
        logic       full;
        logic       pos_bad;
        logic       ptr_end;
        logic       rd_vld;
        logic       hit;
    } t_stat;

endpackage

[design/krt_datapath.sv]
`timescale 1ns / 1ps

module krt_datapath import krt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_res  o_res,
    output logic  o_strobe
);

    t_record r_mem [DEPTH];

    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] n_ptr;
    t_record          r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    t_record          wr_data;
    t_res             r_res;
    t_res             n_res;
    logic             r_strobe;

    assign rd_addr = i_cmd.rd_pos ? IDX_W'(r_req.position) : r_ptr[IDX_W-1:0];
    assign wr_en   = i_cmd.wr_append | i_cmd.wr_set | i_cmd.wr_shift;

    always_comb begin
        wr_addr = r_count[IDX_W-1:0];
        wr_data = '{key: r_req.item_key, qty: r_req.new_quantity, price: r_req.new_price};
        if (i_cmd.wr_set) begin
            wr_addr = r_rd_idx;
            wr_data = '{key: r_rd_data.key, qty: r_req.new_quantity,
                        price: r_rd_data.price};
        end else if (i_cmd.wr_shift) begin
            wr_addr = r_rd_idx - 1'b1;
            wr_data = r_rd_data;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.load) begin
            n_ptr = '0;
        end else if (i_cmd.shift_init) begin
            n_ptr = CNT_W'(r_rd_idx) + 1'b1;
        end else if (i_cmd.issue && !i_cmd.rd_pos) begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.wr_append) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.finish && i_cmd.dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_res = '0;
        n_res.status       = i_cmd.fin_status;
        n_res.record_count = 8'(n_count);
        case (i_cmd.fin_sel)
            SEL_ALL: begin
                n_res.found_key      = r_rd_data.key;
                n_res.found_quantity = r_rd_data.qty;
                n_res.found_price    = r_rd_data.price;
            end
            SEL_QTY: begin
                n_res.found_quantity = r_req.new_quantity;
            end
            default: begin
            end
        endcase
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
        r_ptr <= n_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_cmd.issue;
            r_strobe <= i_cmd.finish;
        end
    end

    assign o_stat.req_type = r_req.req_type;
    assign o_stat.full     = r_count >= CNT_W'(DEPTH);
    assign o_stat.pos_bad  = 32'(r_req.position) >= 32'(r_count);
    assign o_stat.ptr_end  = r_ptr >= r_count;
    assign o_stat.rd_vld   = r_rd_vld;
    assign o_stat.hit      = r_rd_vld && (r_rd_data.key == r_req.item_key);

    assign o_res    = r_res;
    assign o_strobe = r_strobe;

endmodule

[design/krt_ctrl.sv]
`timescale 1ns / 1ps

module krt_ctrl import krt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_READ     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.req_type)
                    REQ_APPEND: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                        if (i_stat.full) begin
                            cmd.fin_status = ST_FULL;
                        end else begin
                            cmd.wr_append = 1'b1;
                        end
                    end
                    REQ_LOOKUP, REQ_SETQTY, REQ_DELETE: begin
                        n_state = S_SCAN;
                    end
                    REQ_READ: begin
                        if (i_stat.pos_bad) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_POS;
                            n_state        = S_IDLE;
                        end else begin
                            cmd.issue  = 1'b1;
                            cmd.rd_pos = 1'b1;
                            n_state    = S_READ;
                        end
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    case (i_stat.req_type)
                        REQ_LOOKUP: begin
                            cmd.finish  = 1'b1;
                            cmd.fin_sel = SEL_ALL;
                            n_state     = S_IDLE;
                        end
                        REQ_SETQTY: begin
                            cmd.wr_set  = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.fin_sel = SEL_QTY;
                            n_state     = S_IDLE;
                        end
                        default: begin
                            cmd.shift_init = 1'b1;
                            n_state        = S_SHIFT;
                        end
                    endcase
                end else if (!i_stat.ptr_end) begin
                    cmd.issue = 1'b1;
                end else if (!i_stat.rd_vld) begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NOKEY;
                    n_state        = S_IDLE;
                end
            end
            S_SHIFT: begin
                // each read entry lands one slot lower in the following cycle
                cmd.wr_shift = i_stat.rd_vld;
                if (!i_stat.ptr_end) begin
                    cmd.issue = 1'b1;
                end else if (!i_stat.rd_vld) begin
                    cmd.finish = 1'b1;
                    cmd.dec    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_READ: begin
                cmd.finish  = 1'b1;
                cmd.fin_sel = SEL_ALL;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_state != S_IDLE;

endmodule

[design/keyed_record_table_top.sv]
`timescale 1ns / 1ps
// channel   | signals                    | transfer when
// ----------+----------------------------+--------------------------
// request   | start, busy, i_req         | start high, busy low
// result    | o_strobe, o_res            | o_strobe high (one cycle)
//
// One request at a time; busy stays high from the cycle after start until
// the result strobe. Append, unknown kinds and refused requests finish at
// dispatch; read at position does one memory read. Lookup and set quantity
// scan up to the hit; delete walks the table once through the single memory
// read port (scan, then shift down). Reset is synchronous and empties the
// table at once (count to zero, no clearing pass). The receiver cannot stall.

`include "keyed_record_table_top_macros.svh"

module keyed_record_table_top import krt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: decodes the request and steps scan / shift
    krt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // record memory, count, scan pointer and result register
    krt_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_res    (o_res),
        .o_strobe (o_strobe)
    );

    // an accepted request holds the block busy
    `KRT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // results come out only once the sequencer is back to idle
    `KRT_ASSERT_SAME(a_strobe_idle, o_strobe, !busy)
    // every result closes a busy period
    `KRT_ASSERT_SAME(a_strobe_after_busy, o_strobe, $past(busy))
    // the count never exceeds the table size
    `KRT_ASSERT_SAME(a_count_range, o_strobe, 32'(o_res.record_count) <= DEPTH)

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import krt_pkg::*;

    // random requests after the directed rows
    localparam int N_RANDOM     = 1625;
    // cycles with no transfer on either side before giving up; must cover a
    // delete at a full table plus the longest sender gap
    localparam int STALL_LIMIT  = 2000;
    // quiet time after the last result, to catch stray strobes
    localparam int DRAIN_CYCLES = 150;

    localparam logic [31:0] V_MIN  = 32'h8000_0000;
    localparam logic [31:0] V_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] V_ONES = 32'hffff_ffff;
    localparam logic [31:0] V_ZERO = 32'h0000_0000;

    // kinds above the last defined one are legal but do nothing
    localparam logic [2:0] REQ_NOP_LO = REQ_READ + 3'd1;
    localparam logic [2:0] REQ_NOP_HI = REQ_READ + 3'd3;

    localparam logic [31:0] VALUE_POOL [8] = '{
        V_MIN, V_MAX, V_ZERO, 32'd1, V_ONES, 32'd100, 32'd42, 32'd7
    };

    typedef struct {
        t_req req;
        bit   typed;    // 1: res below is the expected result
        t_res res;
    } t_plan_row;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic start    = 1'b0;
    t_req i_req    = '0;
    logic busy;
    logic o_strobe;
    t_res o_res;

    keyed_record_table_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the record table. Only entries below tbl_count are
    // ever read, so the untouched tail never matters.
    // ------------------------------------------------------------------
    logic [31:0] tbl_key   [DEPTH];
    logic [31:0] tbl_qty   [DEPTH];
    logic [31:0] tbl_price [DEPTH];
    int          tbl_count = 0;

    t_res        pending_res [$];   // results owed by the block, oldest first
    int unsigned mismatch_cnt = 0;
    int unsigned stall_cycles = 0;
    bit          idle_on = 1'b1;    // sender gaps enabled for this phase
    t_plan_row   plan_rows [$];

    // Applies one request to the shadow table and returns the result the
    // block must give for it.
    function automatic t_res table_apply(input t_req r);
        t_res res;
        int   hit;
        res = '0;
        res.status = ST_DONE;
        hit = -1;
        // first record with the key; duplicates further down are ignored
        for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_key[i] == r.item_key)
                hit = i;
        case (r.req_type)
            REQ_APPEND: begin
                if (tbl_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_key[tbl_count]   = r.item_key;
                    tbl_qty[tbl_count]   = r.new_quantity;
                    tbl_price[tbl_count] = r.new_price;
                    tbl_count++;
                end
            end
            REQ_LOOKUP: begin
                if (hit >= 0) begin
                    res.found_key      = tbl_key[hit];
                    res.found_quantity = tbl_qty[hit];
                    res.found_price    = tbl_price[hit];
                end else begin
                    res.status = ST_NOKEY;
                end
            end
            REQ_SETQTY: begin
                if (hit >= 0) begin
                    tbl_qty[hit] = r.new_quantity;
                    res.found_quantity = r.new_quantity;
                end else begin
                    res.status = ST_NOKEY;
                end
            end
            REQ_DELETE: begin
                if (hit >= 0) begin
                    // close the hole, keeping insertion order
                    for (int j = hit; j + 1 < tbl_count; j++) begin
                        tbl_key[j]   = tbl_key[j + 1];
                        tbl_qty[j]   = tbl_qty[j + 1];
                        tbl_price[j] = tbl_price[j + 1];
                    end
                    tbl_count--;
                end else begin
                    res.status = ST_NOKEY;
                end
            end
            REQ_READ: begin
                if (int'(r.position) < tbl_count) begin
                    res.found_key      = tbl_key[r.position];
                    res.found_quantity = tbl_qty[r.position];
                    res.found_price    = tbl_price[r.position];
                end else begin
                    res.status = ST_POS;
                end
            end
            default: ;  // unknown kind: no change, done, data zero
        endcase
        res.record_count = 8'(tbl_count);
        return res;
    endfunction

    function automatic t_req mk_req(input logic [2:0] kind, input logic [31:0] key,
                                    input logic [31:0] qty, input logic [31:0] price,
                                    input logic [6:0] pos);
        t_req r;
        r.req_type     = kind;
        r.item_key     = key;
        r.new_quantity = qty;
        r.new_price    = price;
        r.position     = pos;
        return r;
    endfunction

    function automatic t_res mk_res(input logic [1:0] st, input logic [31:0] key,
                                    input logic [31:0] qty, input logic [31:0] price,
                                    input logic [7:0] cnt);
        t_res r;
        r.status         = st;
        r.found_key      = key;
        r.found_quantity = qty;
        r.found_price    = price;
        r.record_count   = cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random request shaping
    // ------------------------------------------------------------------

    // Mostly keys already in the table, so lookups, updates and deletes
    // hit; the rest from a small pool (duplicates, extremes) or anywhere.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return VALUE_POOL[$urandom_range(0, 7)];
            default: return (tbl_count != 0) ? tbl_key[$urandom_range(0, tbl_count - 1)]
                                             : $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 7) == 0)
            return VALUE_POOL[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic t_req gen_request(input int unsigned append_pct,
                                         input int unsigned delete_pct);
        t_req        r;
        int unsigned roll;
        int unsigned pos_hi;
        roll = $urandom_range(0, 99);
        if (roll < append_pct)
            r.req_type = REQ_APPEND;
        else if (roll < append_pct + delete_pct)
            r.req_type = REQ_DELETE;
        else if (roll >= 98)
            r.req_type = 3'($urandom_range(REQ_NOP_LO, REQ_NOP_HI));
        else begin
            case ($urandom_range(0, 2))
                0: r.req_type = REQ_LOOKUP;
                1: r.req_type = REQ_SETQTY;
                default: r.req_type = REQ_READ;
            endcase
        end
        r.item_key     = pick_key();
        r.new_quantity = pick_value();
        r.new_price    = pick_value();
        // positions mostly from zero up to the count (at most 127), sometimes anywhere
        pos_hi = (tbl_count > 127) ? 127 : tbl_count;
        if ($urandom_range(0, 4) == 0)
            r.position = 7'($urandom());
        else
            r.position = 7'($urandom_range(0, pos_hi));
        return r;
    endfunction

    // Sender gap: 45% none, 45% short, 10% long; always none when gaps are off.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Called at a falling edge, returns at a falling edge.
    // start stays high across back-to-back requests; it is only lowered
    // when a gap is taken, so it never sees two updates in one step.
    // ------------------------------------------------------------------
    task automatic send_request(input t_req r, input bit typed, input t_res typed_res);
        int unsigned gap;
        t_res        predicted;
        gap = pick_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        // transfer happens at the first rising edge with busy low
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        predicted = table_apply(r);
        pending_res.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: every strobe is a transfer; check it against the
    // oldest expectation, field by field.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_strobe) begin
            if (pending_res.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none, actual %h",
                         $time, o_res);
                mismatch_cnt++;
            end else begin
                want = pending_res.pop_front();
                check_field("status",         32'(want.status),       32'(o_res.status));
                check_field("found_key",      want.found_key,         o_res.found_key);
                check_field("found_quantity", want.found_quantity,    o_res.found_quantity);
                check_field("found_price",    want.found_price,       o_res.found_price);
                check_field("record_count",   32'(want.record_count), 32'(o_res.record_count));
            end
        end
    end

    // Watchdog: too long without a transfer on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL keyed_record_table_top");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned issued;
        int unsigned phase_len;
        int unsigned app_pct;
        int unsigned del_pct;

        // Directed rows. Typed results are the obvious ones; the rest come
        // from the shadow table.
        // empty table: every search misses, every read is out of range
        plan_rows.push_back('{mk_req(REQ_READ, V_ZERO, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_POS, V_ZERO, V_ZERO, V_ZERO, 8'd0)});
        plan_rows.push_back('{mk_req(REQ_LOOKUP, V_ZERO, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_NOKEY, V_ZERO, V_ZERO, V_ZERO, 8'd0)});
        plan_rows.push_back('{mk_req(REQ_SETQTY, V_MAX, 32'd5, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_NOKEY, V_ZERO, V_ZERO, V_ZERO, 8'd0)});
        plan_rows.push_back('{mk_req(REQ_DELETE, V_MIN, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_NOKEY, V_ZERO, V_ZERO, V_ZERO, 8'd0)});
        // unknown kind with every input bit set
        plan_rows.push_back('{mk_req(REQ_NOP_LO, V_ONES, V_ONES, V_ONES, 7'd127), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd0)});
        // extremes, plus a duplicate key appended last
        plan_rows.push_back('{mk_req(REQ_APPEND, V_MIN, V_MAX, V_ONES, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd1)});
        plan_rows.push_back('{mk_req(REQ_APPEND, V_MAX, V_MIN, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd2)});
        plan_rows.push_back('{mk_req(REQ_APPEND, V_ZERO, V_ZERO, 32'd100, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd3)});
        plan_rows.push_back('{mk_req(REQ_APPEND, V_MAX, 32'd7, 32'd1, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd4)});
        plan_rows.push_back('{mk_req(REQ_READ, V_ZERO, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_MIN, V_MAX, V_ONES, 8'd4)});
        plan_rows.push_back('{mk_req(REQ_READ, V_ZERO, V_ZERO, V_ZERO, 7'd127), 1'b1,
                              mk_res(ST_POS, V_ZERO, V_ZERO, V_ZERO, 8'd4)});
        // position equal to count is just out of range
        plan_rows.push_back('{mk_req(REQ_READ, V_ZERO, V_ZERO, V_ZERO, 7'd4), 1'b1,
                              mk_res(ST_POS, V_ZERO, V_ZERO, V_ZERO, 8'd4)});
        // duplicate key: the first record wins
        plan_rows.push_back('{mk_req(REQ_LOOKUP, V_MAX, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_MAX, V_MIN, V_ZERO, 8'd4)});
        plan_rows.push_back('{mk_req(REQ_SETQTY, V_MAX, V_ONES, V_ONES, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ONES, V_ZERO, 8'd4)});
        plan_rows.push_back('{mk_req(REQ_LOOKUP, V_MAX, V_ZERO, V_ZERO, 7'd0), 1'b0, '0});
        plan_rows.push_back('{mk_req(REQ_DELETE, V_MAX, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd3)});
        // now the later duplicate is found; order after the shift
        plan_rows.push_back('{mk_req(REQ_LOOKUP, V_MAX, V_ZERO, V_ZERO, 7'd0), 1'b0, '0});
        plan_rows.push_back('{mk_req(REQ_READ, V_ZERO, V_ZERO, V_ZERO, 7'd1), 1'b0, '0});
        plan_rows.push_back('{mk_req(REQ_NOP_HI, V_ONES, V_ONES, V_ONES, 7'd127), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd3)});
        // delete at the head shifts everything
        plan_rows.push_back('{mk_req(REQ_DELETE, V_MIN, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_ZERO, V_ZERO, 8'd2)});
        plan_rows.push_back('{mk_req(REQ_READ, V_ZERO, V_ZERO, V_ZERO, 7'd0), 1'b0, '0});
        plan_rows.push_back('{mk_req(REQ_SETQTY, V_ZERO, V_MIN, V_ONES, 7'd0), 1'b1,
                              mk_res(ST_DONE, V_ZERO, V_MIN, V_ZERO, 8'd2)});
        plan_rows.push_back('{mk_req(REQ_LOOKUP, V_ZERO, V_ZERO, V_ZERO, 7'd0), 1'b0, '0});
        plan_rows.push_back('{mk_req(REQ_DELETE, 32'd1, V_ZERO, V_ZERO, 7'd0), 1'b1,
                              mk_res(ST_NOKEY, V_ZERO, V_ZERO, V_ZERO, 8'd2)});

        // synchronous reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[i])
            send_request(plan_rows[i].req, plan_rows[i].typed, plan_rows[i].res);

        // Random phases. First fill the table and keep appending into a
        // full table, then drain it to empty, then mixed phases.
        issued = 0;
        for (int phase = 0; issued < N_RANDOM; phase++) begin
            if (phase == 0) begin
                app_pct = 95; del_pct = 0; phase_len = 200;
                idle_on = 1'b1;
            end else if (phase == 1) begin
                app_pct = 2; del_pct = 85; phase_len = 300;
                idle_on = 1'b1;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin app_pct = 70; del_pct = 10; end
                    1: begin app_pct = 30; del_pct = 30; end
                    2: begin app_pct = 5;  del_pct = 80; end
                    default: begin app_pct = 45; del_pct = 20; end
                endcase
                phase_len = $urandom_range(50, 150);
                // some phases run back to back with no sender gaps
                idle_on = ($urandom_range(0, 3) != 0);
            end
            for (int n = 0; n < phase_len && issued < N_RANDOM; n++) begin
                send_request(gen_request(app_pct, del_pct), 1'b0, '0);
                issued++;
            end
        end
        start <= 1'b0;

        // wait for every result, then a quiet spell for stray strobes
        while (pending_res.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("PASS keyed_record_table_top");
        else
            $display("FAIL keyed_record_table_top");
        $finish;
    end

endmodule
